### design/tvt_pkg.sv
`timescale 1ns / 1ps

package tvt_pkg;

  // Field and datapath widths
  localparam int DATA_W    = 32;
  localparam int TIME_W    = 31;
  localparam int FRAC_W    = 16;
  localparam int RAD_W     = 2 * DATA_W;
  localparam int ROOT_W    = RAD_W / 2;
  localparam int CFG_IDX_W = 8;

  // Pipeline depth
  localparam int FRONT_STAGES  = 5;
  localparam int SQ_STAGES     = ROOT_W;
  localparam int MAX_IN_FLIGHT = FRONT_STAGES + SQ_STAGES + 2;

  // Saturation bounds
  localparam logic signed [DATA_W-1:0] VEL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] VEL_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // Register reset values
  localparam logic [DATA_W-1:0] MAX_VEL_RST   = DATA_W'(65536);
  localparam logic [DATA_W-1:0] ACCEL_RST     = DATA_W'(65536);
  localparam logic [DATA_W-1:0] START_VEL_RST = '0;
  localparam logic [DATA_W-1:0] END_VEL_RST   = '0;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_VELOCITY   = CFG_IDX_W'(0),
    CFG_ACCELERATION   = CFG_IDX_W'(1),
    CFG_START_VELOCITY = CFG_IDX_W'(2),
    CFG_END_VELOCITY   = CFG_IDX_W'(3)
  } cfg_idx_t;

  typedef struct packed {
    logic [DATA_W-1:0] max_velocity;
    logic [DATA_W-1:0] acceleration;
    logic [DATA_W-1:0] start_velocity;
    logic [DATA_W-1:0] end_velocity;
  } cfg_regs_t;

  // Branch control that rides alongside the square root
  typedef struct packed {
    logic              dec;
    logic              d_zero;
    logic              same_sign;
    logic [DATA_W-1:0] vel;
  } dec_ctl_t;

endpackage

### design/tvt_in_if.sv
`timescale 1ns / 1ps

interface tvt_in_if;
  import tvt_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] remaining_distance;
  logic        [TIME_W-1:0] elapsed_time;

  modport source (output valid, output remaining_distance, output elapsed_time, input ready);
  modport sink   (input valid, input remaining_distance, input elapsed_time, output ready);
endinterface

### design/tvt_out_if.sv
`timescale 1ns / 1ps

interface tvt_out_if;
  import tvt_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] target_velocity;
  logic                     decelerating;

  modport source (output valid, output target_velocity, output decelerating, input ready);
  modport sink   (input valid, input target_velocity, input decelerating, output ready);
endinterface

### design/tvt_cfg_if.sv
`timescale 1ns / 1ps

interface tvt_cfg_if;
  import tvt_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### design/trapezoidal_velocity_target.sv
// Throughput: one word per cycle while the output skid slot is empty; the 32-stage
// square root pipeline and the five front stages each take one word per cycle whenever that slot is empty.
// A two-slot output (register plus skid) keeps in_chan ready while one result waits.
// Reset (rst_n low, synchronous) empties the pipeline and loads the register defaults.
`timescale 1ns / 1ps

module trapezoidal_velocity_target (
  input logic     clk,
  input logic     rst_n,
  tvt_in_if.sink  in_chan,
  tvt_out_if.source out_chan,
  tvt_cfg_if.sink cfg_chan
);
  import tvt_pkg::*;

  cfg_regs_t         cfg_r;
  logic              adv;
  logic              fr_valid;
  logic [RAD_W-1:0]  fr_rad;
  dec_ctl_t          fr_ctl;
  logic              sq_valid;
  logic [ROOT_W-1:0] sq_root;
  dec_ctl_t          sq_ctl;

  // Register file; writes to unknown indexes drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_velocity   <= MAX_VEL_RST;
      cfg_r.acceleration   <= ACCEL_RST;
      cfg_r.start_velocity <= START_VEL_RST;
      cfg_r.end_velocity   <= END_VEL_RST;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        CFG_MAX_VELOCITY:   cfg_r.max_velocity   <= cfg_chan.data;
        CFG_ACCELERATION:   cfg_r.acceleration   <= cfg_chan.data;
        CFG_START_VELOCITY: cfg_r.start_velocity <= cfg_chan.data;
        CFG_END_VELOCITY:   cfg_r.end_velocity   <= cfg_chan.data;
        default: ;
      endcase
    end
  end

  assign cfg_chan.ready = 1'b1;
  assign in_chan.ready  = adv;

  tvt_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .in_valid    (in_chan.valid),
    .in_distance (in_chan.remaining_distance),
    .in_time     (in_chan.elapsed_time),
    .cfg         (cfg_r),
    .out_valid   (fr_valid),
    .out_rad     (fr_rad),
    .out_ctl     (fr_ctl)
  );

  tvt_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (fr_valid),
    .in_rad    (fr_rad),
    .in_ctl    (fr_ctl),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_ctl   (sq_ctl)
  );

  tvt_out u_out (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (adv),
    .in_valid     (sq_valid),
    .in_root      (sq_root),
    .in_ctl       (sq_ctl),
    .out_valid    (out_chan.valid),
    .out_ready    (out_chan.ready),
    .out_velocity (out_chan.target_velocity),
    .out_dec      (out_chan.decelerating)
  );

endmodule

### design/tvt_front.sv
`timescale 1ns / 1ps

module tvt_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              adv,
  input  logic                              in_valid,
  input  logic signed [tvt_pkg::DATA_W-1:0] in_distance,
  input  logic        [tvt_pkg::TIME_W-1:0] in_time,
  input  tvt_pkg::cfg_regs_t                cfg,
  output logic                              out_valid,
  output logic        [tvt_pkg::RAD_W-1:0]  out_rad,
  output tvt_pkg::dec_ctl_t                 out_ctl
);
  import tvt_pkg::*;

  localparam int SUM_W = RAD_W - FRAC_W + 1;

  logic signed [DATA_W-1:0] acc_s, mv_s, v0_s, v1_s, time_s;
  logic                     a_zero, a_pos;

  // Stage 1: products
  logic signed [RAD_W-1:0]  acc_prod_nxt, p_nxt, v1sq_nxt;
  logic                     s1_vld_r, s1_dz_r, s1_dpos_r;
  logic signed [RAD_W-1:0]  s1_acc_r, s1_p_r, s1_v1sq_r;

  // Stage 2: start velocity plus ramp, saturated
  logic        [SUM_W-1:0]  sum;
  logic signed [DATA_W-1:0] vel_sat_nxt;
  logic                     s2_vld_r, s2_dz_r, s2_dpos_r;
  logic signed [DATA_W-1:0] s2_vel_r;
  logic signed [RAD_W-1:0]  s2_p_r, s2_v1sq_r;

  // Stage 3: velocity limit
  logic signed [DATA_W-1:0] mv_neg, vel_lim_nxt;
  logic                     s3_vld_r, s3_dz_r, s3_dpos_r;
  logic signed [DATA_W-1:0] s3_vel_r;
  logic signed [RAD_W-1:0]  s3_p_r, s3_v1sq_r;

  // Stage 4: velocity squared
  logic signed [RAD_W-1:0]  vsq_nxt;
  logic                     s4_vld_r, s4_dz_r, s4_dpos_r;
  logic signed [DATA_W-1:0] s4_vel_r;
  logic signed [RAD_W-1:0]  s4_vsq_r, s4_p_r, s4_v1sq_r;

  // Stage 5: braking test and radicand
  logic signed [RAD_W:0]    p2, diff;
  logic signed [RAD_W+1:0]  mag_s, mag_neg;
  logic        [RAD_W-1:0]  rad_nxt;
  dec_ctl_t                 ctl_nxt;
  logic                     s5_vld_r;
  logic        [RAD_W-1:0]  s5_rad_r;
  dec_ctl_t                 s5_ctl_r;

  assign acc_s  = cfg.acceleration;
  assign mv_s   = cfg.max_velocity;
  assign v0_s   = cfg.start_velocity;
  assign v1_s   = cfg.end_velocity;
  assign time_s = {1'b0, in_time};
  assign a_zero = (acc_s == '0);
  assign a_pos  = !acc_s[DATA_W-1] && !a_zero;

  assign acc_prod_nxt = acc_s * time_s;
  assign p_nxt        = acc_s * in_distance;
  assign v1sq_nxt     = v1_s * v1_s;

  // Floor the ramp to Q16.16 by dropping the fraction, then clamp the sum
  assign sum = {{(SUM_W-DATA_W){v0_s[DATA_W-1]}}, v0_s}
             + {s1_acc_r[RAD_W-1], s1_acc_r[RAD_W-1:FRAC_W]};

  always_comb begin
    if (!sum[SUM_W-1] && (|sum[SUM_W-2:DATA_W-1])) begin
      vel_sat_nxt = VEL_MAX;
    end else if (sum[SUM_W-1] && !(&sum[SUM_W-2:DATA_W-1])) begin
      vel_sat_nxt = VEL_MIN;
    end else begin
      vel_sat_nxt = sum[DATA_W-1:0];
    end
  end

  // Clamp to the limit; a negative velocity above the limit takes the mirrored limit, zero stays zero
  assign mv_neg = (mv_s == VEL_MIN) ? VEL_MAX : -mv_s;

  always_comb begin
    vel_lim_nxt = s2_vel_r;
    if (s2_vel_r > mv_s) begin
      if (s2_vel_r[DATA_W-1]) begin
        vel_lim_nxt = mv_neg;
      end else if (s2_vel_r != '0) begin
        vel_lim_nxt = mv_s;
      end else begin
        vel_lim_nxt = '0;
      end
    end
  end

  assign vsq_nxt = s3_vel_r * s3_vel_r;

  // Cross-multiplied braking test: 2*a*d against v^2 - v1^2, direction by sign of a
  assign p2      = {s4_p_r, 1'b0};
  assign diff    = {s4_vsq_r[RAD_W-1], s4_vsq_r} - {s4_v1sq_r[RAD_W-1], s4_v1sq_r};
  assign mag_s   = {{2{s4_v1sq_r[RAD_W-1]}}, s4_v1sq_r} + {p2[RAD_W], p2};
  assign mag_neg = -mag_s;
  assign rad_nxt = mag_s[RAD_W+1] ? mag_neg[RAD_W-1:0] : mag_s[RAD_W-1:0];

  always_comb begin
    ctl_nxt           = '0;
    ctl_nxt.dec       = !a_zero && (a_pos ? (p2 <= diff) : (p2 >= diff));
    ctl_nxt.d_zero    = s4_dz_r;
    ctl_nxt.same_sign = (a_pos == s4_dpos_r);
    ctl_nxt.vel       = s4_vel_r;
  end

  // Valid bits advance with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_valid;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
      s5_vld_r <= s4_vld_r;
    end
  end

  // Payload; hold on stall
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_acc_r  <= acc_prod_nxt;
      s1_p_r    <= p_nxt;
      s1_v1sq_r <= v1sq_nxt;
      s1_dz_r   <= (in_distance == '0);
      s1_dpos_r <= !in_distance[DATA_W-1] && (in_distance != '0);

      s2_vel_r  <= vel_sat_nxt;
      s2_p_r    <= s1_p_r;
      s2_v1sq_r <= s1_v1sq_r;
      s2_dz_r   <= s1_dz_r;
      s2_dpos_r <= s1_dpos_r;

      s3_vel_r  <= vel_lim_nxt;
      s3_p_r    <= s2_p_r;
      s3_v1sq_r <= s2_v1sq_r;
      s3_dz_r   <= s2_dz_r;
      s3_dpos_r <= s2_dpos_r;

      s4_vel_r  <= s3_vel_r;
      s4_vsq_r  <= vsq_nxt;
      s4_p_r    <= s3_p_r;
      s4_v1sq_r <= s3_v1sq_r;
      s4_dz_r   <= s3_dz_r;
      s4_dpos_r <= s3_dpos_r;

      s5_rad_r  <= rad_nxt;
      s5_ctl_r  <= ctl_nxt;
    end
  end

  assign out_valid = s5_vld_r;
  assign out_rad   = s5_rad_r;
  assign out_ctl   = s5_ctl_r;

endmodule

### design/tvt_sqrt.sv
`timescale 1ns / 1ps

module tvt_sqrt (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             adv,
  input  logic                             in_valid,
  input  logic        [tvt_pkg::RAD_W-1:0] in_rad,
  input  tvt_pkg::dec_ctl_t                in_ctl,
  output logic                             out_valid,
  output logic       [tvt_pkg::ROOT_W-1:0] out_root,
  output tvt_pkg::dec_ctl_t                out_ctl
);
  import tvt_pkg::*;

  logic              vld_r   [SQ_STAGES];
  logic [RAD_W-1:0]  rem_r   [SQ_STAGES];
  logic [ROOT_W-1:0] root_r  [SQ_STAGES];
  dec_ctl_t          ctl_r   [SQ_STAGES];

  logic              vld_in  [SQ_STAGES];
  logic [RAD_W-1:0]  rem_in  [SQ_STAGES];
  logic [ROOT_W-1:0] root_in [SQ_STAGES];
  dec_ctl_t          ctl_in  [SQ_STAGES];
  logic [RAD_W-1:0]  rem_nxt [SQ_STAGES];
  logic [ROOT_W-1:0] root_nxt[SQ_STAGES];

  // One root bit per stage, most significant first
  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_stage
    localparam int B = ROOT_W - 1 - k;

    logic [RAD_W+1:0] trial;
    logic             fits;

    if (k == 0) begin : g_first
      assign vld_in[k]  = in_valid;
      assign rem_in[k]  = in_rad;
      assign root_in[k] = '0;
      assign ctl_in[k]  = in_ctl;
    end else begin : g_next
      assign vld_in[k]  = vld_r[k-1];
      assign rem_in[k]  = rem_r[k-1];
      assign root_in[k] = root_r[k-1];
      assign ctl_in[k]  = ctl_r[k-1];
    end

    // (root + 2^B)^2 - root^2 = root * 2^(B+1) + 2^(2B)
    assign trial = ({{(RAD_W+2-ROOT_W){1'b0}}, root_in[k]} << (B + 1))
                 + ((RAD_W+2)'(1) << (2 * B));
    assign fits  = ({2'b00, rem_in[k]} >= trial);

    assign rem_nxt[k]  = fits ? (rem_in[k] - trial[RAD_W-1:0]) : rem_in[k];
    assign root_nxt[k] = fits ? (root_in[k] | (ROOT_W'(1) << B)) : root_in[k];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < SQ_STAGES; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else if (adv) begin
      for (int k = 0; k < SQ_STAGES; k++) begin
        vld_r[k] <= vld_in[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < SQ_STAGES; k++) begin
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
        ctl_r[k]  <= ctl_in[k];
      end
    end
  end

  assign out_valid = vld_r[SQ_STAGES-1];
  assign out_root  = root_r[SQ_STAGES-1];
  assign out_ctl   = ctl_r[SQ_STAGES-1];

endmodule

### design/tvt_out.sv
`timescale 1ns / 1ps

module tvt_out (
  input  logic                              clk,
  input  logic                              rst_n,
  output logic                              adv,
  input  logic                              in_valid,
  input  logic        [tvt_pkg::ROOT_W-1:0] in_root,
  input  tvt_pkg::dec_ctl_t                 in_ctl,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [tvt_pkg::DATA_W-1:0] out_velocity,
  output logic                              out_dec
);
  import tvt_pkg::*;

  logic signed [DATA_W-1:0] vel_nxt;
  logic signed [DATA_W-1:0] root_s;
  logic                     out_vld_r, skid_vld_r;
  logic signed [DATA_W-1:0] out_vel_r, skid_vel_r;
  logic                     out_dec_r, skid_dec_r;
  logic                     load;

  assign root_s = in_root;

  // Apply sign and saturate the braking root, zero for zero distance; otherwise pass the limited ramp
  always_comb begin
    if (!in_ctl.dec) begin
      vel_nxt = in_ctl.vel;
    end else if (in_ctl.d_zero) begin
      vel_nxt = '0;
    end else if (in_ctl.same_sign) begin
      vel_nxt = in_root[ROOT_W-1] ? VEL_MAX : root_s;
    end else begin
      vel_nxt = in_root[ROOT_W-1] ? VEL_MIN : -root_s;
    end
  end

  // Pipeline moves while the skid slot is free
  assign adv  = !skid_vld_r;
  assign load = adv && in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (out_vld_r && out_ready) begin
      if (skid_vld_r) begin
        skid_vld_r <= 1'b0;
      end else begin
        out_vld_r <= load;
      end
    end else if (!out_vld_r) begin
      out_vld_r <= load;
    end else if (load) begin
      skid_vld_r <= 1'b1;
    end
  end

  // Word registers
  always_ff @(posedge clk) begin
    if (out_vld_r && out_ready && skid_vld_r) begin
      out_vel_r <= skid_vel_r;
      out_dec_r <= skid_dec_r;
    end else if (load && (!out_vld_r || out_ready)) begin
      out_vel_r <= vel_nxt;
      out_dec_r <= in_ctl.dec;
    end
    if (load && out_vld_r && !out_ready) begin
      skid_vel_r <= vel_nxt;
      skid_dec_r <= in_ctl.dec;
    end
  end

  assign out_valid    = out_vld_r;
  assign out_velocity = out_vel_r;
  assign out_dec      = out_dec_r;

endmodule

### design/tvt_chk.sv
`timescale 1ns / 1ps

module tvt_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [tvt_pkg::DATA_W-1:0] out_velocity
);
  import tvt_pkg::*;

  localparam int CNT_W = $clog2(MAX_IN_FLIGHT + 1) + 1;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // Track words accepted but not yet delivered
  always_comb begin
    cnt_nxt = cnt_r;
    if (in_valid && in_ready) begin
      cnt_nxt = cnt_nxt + CNT_W'(1);
    end
    if (out_valid && out_ready) begin
      cnt_nxt = cnt_nxt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_velocity))
    else $error("result word changed while stalled");

  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |-> cnt_r != '0)
    else $error("result word without a pending input word");

  a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_IN_FLIGHT))
    else $error("more words in flight than pipeline slots");

  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled while output register is empty");

endmodule

bind trapezoidal_velocity_target tvt_chk u_tvt_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_chan.valid),
  .in_ready     (in_chan.ready),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .out_velocity (out_chan.target_velocity)
);

### verif/tvt_velocity_checker.sv
`timescale 1ns / 1ps

module tvt_velocity_checker (
  input  logic clk,
  input  logic rst_n,
  tvt_in_if    in_chan,
  tvt_out_if   out_chan,
  tvt_cfg_if   cfg_chan,
  output int   mismatches,
  output int   outstanding
);
  import tvt_pkg::*;

  // Wide enough for v*v, a*d and the radicand without overflow
  localparam int WIDE_W = 72;

  typedef struct packed {
    logic [DATA_W-1:0] target_velocity;
    logic              decelerating;
  } velocity_word_t;

  logic signed [DATA_W-1:0] max_vel_q;
  logic signed [DATA_W-1:0] accel_q;
  logic signed [DATA_W-1:0] start_vel_q;
  logic signed [DATA_W-1:0] end_vel_q;

  velocity_word_t pending_velocities[$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  function automatic logic signed [DATA_W-1:0] clamp_word(input logic signed [WIDE_W-1:0] x);
    if (x > VEL_MAX) return VEL_MAX;
    if (x < VEL_MIN) return VEL_MIN;
    return x[DATA_W-1:0];
  endfunction

  // Greedy bit-by-bit floor square root of a 64-bit radicand
  function automatic logic [DATA_W-1:0] floor_sqrt(input logic [RAD_W-1:0] n);
    logic [DATA_W-1:0] r;
    logic [DATA_W-1:0] cand;
    logic [RAD_W-1:0]  sq;
    r = '0;
    for (int i = DATA_W - 1; i >= 0; i--) begin
      cand = r | (DATA_W'(1) << i);
      sq   = {{DATA_W{1'b0}}, cand} * {{DATA_W{1'b0}}, cand};
      if (sq <= n) r = cand;
    end
    return r;
  endfunction

  function automatic velocity_word_t predict_velocity(input logic signed [DATA_W-1:0] rem_dist,
                                                      input logic [TIME_W-1:0] t_el);
    logic signed [WIDE_W-1:0] rate, vlim, vstart, vend, dd, tt, vel, prod, diff, mag;
    logic [DATA_W-1:0] root;
    logic take;
    velocity_word_t res;
    rate   = accel_q;
    vlim   = max_vel_q;
    vstart = start_vel_q;
    vend   = end_vel_q;
    dd     = rem_dist;
    tt     = {{(WIDE_W - TIME_W){1'b0}}, t_el};

    // Acceleration phase: floor the Q32.32 product back to Q16.16, then clamp
    vel = clamp_word(vstart + ((rate * tt) >>> FRAC_W));

    // Apply the velocity limit; a negative velocity above it flips to -limit, zero stays zero
    if (vel > vlim) begin
      if (vel > 0) vel = vlim;
      else if (vel < 0) vel = clamp_word(-vlim);
    end

    res.decelerating    = 1'b0;
    res.target_velocity = vel[DATA_W-1:0];

    // Deceleration test by exact cross-multiplication; skipped for zero rate
    if (rate != 0) begin
      prod = rate * dd;
      diff = vel * vel - vend * vend;
      if (rate > 0) take = (prod <= (diff >>> 1));
      else take = (prod >= ((diff + 1) >>> 1));
      if (take) begin
        mag = vend * vend + 2 * prod;
        if (mag < 0) mag = -mag;
        root = floor_sqrt(mag[RAD_W-1:0]);
        res.decelerating = 1'b1;
        if (dd == 0) begin
          res.target_velocity = '0;
        end else if ((rate > 0) == (dd > 0)) begin
          res.target_velocity = root[DATA_W-1] ? VEL_MAX : root;
        end else begin
          res.target_velocity = root[DATA_W-1] ? VEL_MIN : -root;
        end
      end
    end
    return res;
  endfunction

  // Track registers, check result words, queue predictions for input words
  always @(posedge clk) begin
    velocity_word_t want;
    if (!rst_n) begin
      max_vel_q   <= MAX_VEL_RST;
      accel_q     <= ACCEL_RST;
      start_vel_q <= START_VEL_RST;
      end_vel_q   <= END_VEL_RST;
      pending_velocities.delete();
    end else begin
      if (cfg_chan.valid && cfg_chan.ready) begin
        case (cfg_chan.index)
          CFG_MAX_VELOCITY:   max_vel_q   <= cfg_chan.data;
          CFG_ACCELERATION:   accel_q     <= cfg_chan.data;
          CFG_START_VELOCITY: start_vel_q <= cfg_chan.data;
          CFG_END_VELOCITY:   end_vel_q   <= cfg_chan.data;
          default: ;
        endcase
      end

      if (out_chan.valid && out_chan.ready) begin
        if (pending_velocities.size() == 0) begin
          mismatches++;
          $display("%0t velocity_check: unexpected word, got velocity %0d dec %0b", $time,
                   $signed(out_chan.target_velocity), out_chan.decelerating);
        end else begin
          want = pending_velocities.pop_front();
          if (out_chan.target_velocity !== want.target_velocity) begin
            mismatches++;
            $display("%0t velocity_check: target_velocity expected %0d, got %0d", $time,
                     $signed(want.target_velocity), $signed(out_chan.target_velocity));
          end
          if (out_chan.decelerating !== want.decelerating) begin
            mismatches++;
            $display("%0t velocity_check: decelerating expected %0b, got %0b", $time,
                     want.decelerating, out_chan.decelerating);
          end
        end
      end

      if (in_chan.valid && in_chan.ready) begin
        pending_velocities.push_back(predict_velocity(in_chan.remaining_distance,
                                                      in_chan.elapsed_time));
      end
    end
    outstanding = pending_velocities.size();
  end

endmodule

### verif/tb_trapezoidal_velocity_target.sv
`timescale 1ns / 1ps

module tb_trapezoidal_velocity_target;
  import tvt_pkg::*;

  // Index with no register behind it; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = CFG_IDX_W'(4);
  localparam int ITEMS_PER_SETTING = 85;
  localparam int NUM_SETTINGS      = 12;

  // Q16.16 constants used by the preset settings
  localparam logic [DATA_W-1:0] Q_ONE     = 32'h0001_0000;
  localparam logic [DATA_W-1:0] Q_HALF    = 32'h0000_8000;
  localparam logic [DATA_W-1:0] Q_TWO     = 32'h0002_0000;
  localparam logic [DATA_W-1:0] Q_THREE   = 32'h0003_0000;
  localparam logic [DATA_W-1:0] Q_TEN     = 32'h000A_0000;
  localparam logic [DATA_W-1:0] Q_NEG_ONE = 32'hFFFF_0000;
  localparam logic [DATA_W-1:0] Q_NEG_TWO = 32'hFFFE_0000;
  localparam logic [DATA_W-1:0] Q_NEG_3   = 32'hFFFD_0000;
  localparam logic [DATA_W-1:0] Q_ZERO    = 32'h0000_0000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   mismatches;
  int   outstanding;
  int   in_idle_pct;
  int   out_stall_pct;

  tvt_in_if  in_chan();
  tvt_out_if out_chan();
  tvt_cfg_if cfg_chan();

  trapezoidal_velocity_target dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  tvt_velocity_checker velocity_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .out_chan    (out_chan),
    .cfg_chan    (cfg_chan),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Stall the result side at random
  always @(negedge clk) begin
    out_chan.ready = ($urandom_range(0, 99) >= out_stall_pct);
  end

  // Mix of extremes, full-range words and log-spread magnitudes of either sign
  function automatic logic [DATA_W-1:0] spread_word();
    logic [DATA_W-1:0] raw;
    raw = $urandom;
    case ($urandom_range(0, 7))
      0: return VEL_MAX;
      1: return VEL_MIN;
      2: return '0;
      3, 4: return raw;
      default: return $signed(raw) >>> $urandom_range(1, 31);
    endcase
  endfunction

  function automatic cfg_regs_t preset_regs(input int k);
    cfg_regs_t r;
    case (k)
      0: r = {Q_TWO, Q_HALF, Q_ZERO, Q_ZERO};
      1: r = {VEL_MIN, Q_ONE, Q_NEG_ONE, Q_ZERO};
      2: r = {Q_NEG_TWO, Q_ONE, Q_NEG_ONE, Q_HALF};
      3: r = {VEL_MAX, Q_ZERO, Q_THREE, Q_ONE};
      4: r = {VEL_MAX, VEL_MIN, VEL_MAX, VEL_MIN};
      5: r = {VEL_MAX, VEL_MAX, VEL_MIN, VEL_MIN};
      6: r = {Q_TEN, Q_NEG_TWO, Q_ZERO, Q_NEG_3};
      7: r = {VEL_MIN, VEL_MAX, VEL_MAX, VEL_MAX};
      default: r = {spread_word(), spread_word(), spread_word(), spread_word()};
    endcase
    return r;
  endfunction

  task automatic set_idling(input int mode);
    case (mode)
      0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
      1: begin in_idle_pct = 73; out_stall_pct = 0;  end
      2: begin in_idle_pct = 0;  out_stall_pct = 73; end
      default: begin in_idle_pct = 13; out_stall_pct = 13; end
    endcase
  endtask

  // Present one word after random idle cycles; return at the falling edge after it is taken
  task automatic send_item(input logic [DATA_W-1:0] d, input logic [TIME_W-1:0] t);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_chan.valid = 1'b0;
      @(negedge clk);
    end
    in_chan.valid              = 1'b1;
    in_chan.remaining_distance = d;
    in_chan.elapsed_time       = t;
    do @(posedge clk); while (!in_chan.ready);
    @(negedge clk);
  endtask

  // Leaves valid high; the caller drops it after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    cfg_chan.valid = 1'b1;
    cfg_chan.index = idx;
    cfg_chan.data  = value;
    do @(posedge clk); while (!cfg_chan.ready);
    @(negedge clk);
  endtask

  task automatic program_regs(input cfg_regs_t r);
    write_reg(CFG_SPARE_INDEX, spread_word());
    write_reg(CFG_MAX_VELOCITY, r.max_velocity);
    write_reg(CFG_ACCELERATION, r.acceleration);
    write_reg(CFG_START_VELOCITY, r.start_velocity);
    write_reg(CFG_END_VELOCITY, r.end_velocity);
    cfg_chan.valid = 1'b0;
  endtask

  task automatic wait_idle();
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic send_random(input int count);
    repeat (count) send_item(spread_word(), TIME_W'(spread_word()));
    in_chan.valid = 1'b0;
  endtask

  initial begin
    in_chan.valid              = 1'b0;
    in_chan.remaining_distance = '0;
    in_chan.elapsed_time       = '0;
    out_chan.ready             = 1'b0;
    cfg_chan.valid             = 1'b0;
    cfg_chan.index             = '0;
    cfg_chan.data              = '0;
    set_idling(0);

    // Hold reset, release on a falling edge
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed words at the reset settings (limit 1.0, rate 1.0, rest zero)
    send_item(32'h0000_0000, 31'h0000_0000);
    send_item(VEL_MAX, 31'h0000_0000);
    send_item(VEL_MIN, 31'h0000_0000);
    send_item(32'h0000_0001, 31'h0000_0000);
    send_item(32'hFFFF_FFFF, 31'h0000_0000);
    send_item(32'h0000_0000, 31'h7FFF_FFFF);
    send_item(VEL_MAX, 31'h7FFF_FFFF);
    send_item(VEL_MIN, 31'h7FFF_FFFF);
    send_item(32'h0000_8000, 31'h0001_0000);
    send_item(32'h0000_8001, 31'h0001_0000);
    send_item(32'hFFFF_8000, 31'h0001_0000);
    send_item(32'h0000_4000, 31'h0000_8000);
    send_item(32'h5555_5555, 31'h2AAA_AAAA);
    send_item(32'hAAAA_AAAA, 31'h5555_5555);
    send_item(32'h0000_0100, 31'h0000_0010);
    send_item(32'hFFFF_F000, 31'h7FFF_0000);
    in_chan.valid = 1'b0;

    set_idling(3);
    send_random(ITEMS_PER_SETTING);

    // Reprogram only with the pipeline drained, then rotate the idling mode
    for (int s = 0; s < NUM_SETTINGS; s++) begin
      wait_idle();
      program_regs(preset_regs(s));
      set_idling(s % 4);
      send_random(ITEMS_PER_SETTING);
    end

    // Drain, then give late extra words a chance to show up
    set_idling(0);
    wait_idle();
    repeat (MAX_IN_FLIGHT + 8) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb_trapezoidal_velocity_target OK");
    end else begin
      $display("tb_trapezoidal_velocity_target NOT OK");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("tb_trapezoidal_velocity_target NOT OK");
    $finish;
  end

endmodule
